@@ hw/rtl/trimmed_mean_averager_assert.svh @@
// ----------------------------------------------------------------------------
// Trimmed mean averager assertion macros
// Concurrent assertion wrappers sampled on clock and disabled during reset.
// Define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef TRIMMED_MEAN_AVERAGER_ASSERT_SVH
`define TRIMMED_MEAN_AVERAGER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset
`define TMA_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("trimmed_mean_averager: assertion failed");

// Expression must never be true outside reset
`define TMA_ASSERT_NEVER(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("trimmed_mean_averager: forbidden condition seen");

`else

`define TMA_ASSERT(lbl, prop)
`define TMA_ASSERT_NEVER(lbl, expr)

`endif

`endif

@@ hw/rtl/tma_pkg.sv @@
// ----------------------------------------------------------------------------
// Trimmed mean averager package
// Shared types and fixed constants for the averager and its sub-units.
// ----------------------------------------------------------------------------
package tma_pkg;

   // Data path width of samples, sum, count and average
   localparam int DATA_W = 32;
   // Width of the count registers
   localparam int CNT_W  = 4;

   // Request kinds
   localparam logic KIND_ADD   = 1'b0;
   localparam logic KIND_CLEAR = 1'b1;

   // Register indexes
   localparam logic CSR_MIN_COUNT = 1'b0;
   localparam logic CSR_MAX_COUNT = 1'b1;

   // Sequencer to store control
   typedef struct packed {
      logic start;
      logic clear;
   } st_req_type;

   // Store to sequencer status
   typedef struct packed {
      logic done;
      logic absorbed;
   } st_rsp_type;

endpackage

@@ hw/rtl/tma_store.sv @@
// ----------------------------------------------------------------------------
// Extreme value store
// Keeps up to DEPTH extreme samples in a small memory. Fills first, then
// scans one entry per cycle with a single shared comparator and swaps the
// sample in when it is more extreme than the weakest kept entry.
// ----------------------------------------------------------------------------
module tma_store #(
   parameter int DEPTH      = 8,
   parameter bit WANT_SMALL = 1'b1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [tma_pkg::CNT_W-1:0]  cfg_count,
   input  tma_pkg::st_req_type        ctl,
   input  logic [tma_pkg::DATA_W-1:0] value_in,
   output tma_pkg::st_rsp_type        sts,
   output logic [tma_pkg::DATA_W-1:0] pass_out
);

   localparam int FW = $clog2(DEPTH + 1);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = (FW > tma_pkg::CNT_W) ? FW : tma_pkg::CNT_W;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_DECIDE = 2'd2;

   logic [tma_pkg::DATA_W-1:0] mem [DEPTH];

   logic [1:0]                 state_ff, state_in;
   logic [FW-1:0]              fill_ff, fill_in;
   logic [FW-1:0]              issue_ff, issue_in;
   logic                       pend_ff, pend_in;
   logic [AW-1:0]              pend_idx_ff, pend_idx_in;
   logic [tma_pkg::DATA_W-1:0] rdata_ff;
   logic [tma_pkg::DATA_W-1:0] best_ff, best_in;
   logic [AW-1:0]              best_idx_ff, best_idx_in;
   logic [tma_pkg::DATA_W-1:0] val_ff, val_in;
   logic [tma_pkg::DATA_W-1:0] pass_ff, pass_in;
   logic                       done_ff, done_in;
   logic                       absorbed_ff, absorbed_in;

   logic                       mem_we, mem_re;
   logic [AW-1:0]              mem_waddr, mem_raddr;
   logic [tma_pkg::DATA_W-1:0] mem_wdata;

   logic [CW-1:0]              cfg_ext, depth_c, n_wide;
   logic [FW-1:0]              n_eff;
   logic [tma_pkg::DATA_W-1:0] cmp_a, cmp_b;
   logic                       cmp_better;

   // Effective count, limited to the store depth
   assign cfg_ext = CW'(cfg_count);
   assign depth_c = CW'(DEPTH);
   assign n_wide  = (cfg_ext > depth_c) ? depth_c : cfg_ext;
   assign n_eff   = n_wide[FW-1:0];

   // Shared comparator: scan picks the weakest entry, decide tests the sample
   assign cmp_a      = (state_ff == S_DECIDE) ? best_ff : rdata_ff;
   assign cmp_b      = (state_ff == S_DECIDE) ? val_ff : best_ff;
   assign cmp_better = WANT_SMALL ? (cmp_a > cmp_b) : (cmp_a < cmp_b);

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      issue_in    = issue_ff;
      pend_in     = 1'b0;
      pend_idx_in = pend_idx_ff;
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      val_in      = val_ff;
      pass_in     = pass_ff;
      done_in     = 1'b0;
      absorbed_in = 1'b0;
      mem_we      = 1'b0;
      mem_waddr   = fill_ff[AW-1:0];
      mem_wdata   = value_in;
      mem_re      = 1'b0;
      mem_raddr   = issue_ff[AW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (ctl.clear) begin
               fill_in = '0;
            end else if (ctl.start) begin
               if (n_eff == '0) begin
                  // store disabled: forward as is
                  pass_in = value_in;
                  done_in = 1'b1;
               end else if (fill_ff < n_eff) begin
                  mem_we      = 1'b1;
                  fill_in     = fill_ff + FW'(1);
                  done_in     = 1'b1;
                  absorbed_in = 1'b1;
               end else begin
                  val_in   = value_in;
                  issue_in = '0;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // issue one read per cycle
            if (issue_ff < n_eff) begin
               mem_re      = 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = issue_ff[AW-1:0];
               issue_in    = issue_ff + FW'(1);
            end
            // fold returned entry; lowest index wins ties
            if (pend_ff) begin
               if (pend_idx_ff == '0 || cmp_better) begin
                  best_in     = rdata_ff;
                  best_idx_in = pend_idx_ff;
               end
            end else if (issue_ff == n_eff) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            done_in  = 1'b1;
            state_in = S_IDLE;
            if (cmp_better) begin
               mem_we    = 1'b1;
               mem_waddr = best_idx_ff;
               mem_wdata = val_ff;
               pass_in   = best_ff;
            end else begin
               pass_in = val_ff;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Memory: one write port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         fill_ff     <= '0;
         pend_ff     <= 1'b0;
         done_ff     <= 1'b0;
         absorbed_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         pend_ff     <= pend_in;
         done_ff     <= done_in;
         absorbed_ff <= absorbed_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      issue_ff    <= issue_in;
      pend_idx_ff <= pend_idx_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      val_ff      <= val_in;
      pass_ff     <= pass_in;
   end

   assign sts.done     = done_ff;
   assign sts.absorbed = absorbed_ff;
   assign pass_out     = pass_ff;

endmodule

@@ hw/rtl/tma_div.sv @@
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned divide, one quotient bit per cycle, done pulses after DATA_W steps.
// ----------------------------------------------------------------------------
module tma_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [tma_pkg::DATA_W-1:0] dividend,
   input  logic [tma_pkg::DATA_W-1:0] divisor,
   output logic                       done,
   output logic [tma_pkg::DATA_W-1:0] quotient,
   output logic [tma_pkg::DATA_W-1:0] remainder
);

   localparam int W  = tma_pkg::DATA_W;
   localparam int SW = $clog2(W + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [SW-1:0] step_ff, step_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  dvs_ff, dvs_in;
   logic [W:0]    trial, diff;
   logic          fits;

   // Shift in next dividend bit and trial subtract
   assign trial = {rem_ff, quo_ff[W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         step_in = SW'(W);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[W-1:0] : trial[W-1:0];
         quo_in  = {quo_ff[W-2:0], fits};
         step_in = step_ff - SW'(1);
         if (step_ff == SW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

@@ hw/rtl/trimmed_mean_averager.sv @@
// A clear skips both stores, a sample the minima store keeps skips the maxima
//   store, and a zero count skips the divider.
// One request at a time, taken the cycle after its response loads; a response
//   waits to load while rsp_ready is held low.
// Reset (synchronous, active high) clears counts, fills, sum and handshakes.
// ----------------------------------------------------------------------------
// Trimmed mean averager
// Sequencer around a minima store, a maxima store and a restoring divider.
// Samples surviving both stores are summed; each request returns the mean.
// ----------------------------------------------------------------------------
`include "trimmed_mean_averager_assert.svh"

module trimmed_mean_averager #(
   parameter int MIN_DEPTH = 8,
   parameter int MAX_DEPTH = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_kind,
   input  logic [tma_pkg::DATA_W-1:0] req_sample,
   // response channel
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [tma_pkg::DATA_W-1:0] rsp_average,
   output logic                       rsp_ready_res,
   // register writes
   input  logic                       csr_write_en,
   input  logic                       csr_index,
   input  logic [tma_pkg::CNT_W-1:0]  csr_wdata
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MIN  = 3'd1;
   localparam logic [2:0] S_MAX  = 3'd2;
   localparam logic [2:0] S_CALC = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   logic [2:0]                 state_ff, state_in;
   logic [tma_pkg::CNT_W-1:0]  min_cnt_ff, max_cnt_ff;
   logic [tma_pkg::DATA_W-1:0] sum_ff, sum_in;
   logic [tma_pkg::DATA_W-1:0] count_ff, count_in;
   logic [tma_pkg::DATA_W-1:0] avg_ff, avg_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [tma_pkg::DATA_W-1:0] rsp_average_ff, rsp_average_in;
   logic                       rsp_ready_res_ff, rsp_ready_res_in;

   logic                       accept;
   tma_pkg::st_req_type        min_req, max_req;
   tma_pkg::st_rsp_type        min_rsp, max_rsp;
   logic [tma_pkg::DATA_W-1:0] min_pass, max_pass;
   logic                       div_start, div_done;
   logic [tma_pkg::DATA_W-1:0] div_quo, div_rem;
   logic                       round_up;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   // Store control
   assign min_req.start = accept && (req_kind == tma_pkg::KIND_ADD);
   assign min_req.clear = accept && (req_kind == tma_pkg::KIND_CLEAR);
   assign max_req.start = (state_ff == S_MIN) && min_rsp.done && !min_rsp.absorbed;
   assign max_req.clear = min_req.clear;

   tma_store #(
      .DEPTH      (MIN_DEPTH),
      .WANT_SMALL (1'b1)
   ) u_min_store (
      .clock     (clock),
      .reset     (reset),
      .cfg_count (min_cnt_ff),
      .ctl       (min_req),
      .value_in  (req_sample),
      .sts       (min_rsp),
      .pass_out  (min_pass)
   );

   tma_store #(
      .DEPTH      (MAX_DEPTH),
      .WANT_SMALL (1'b0)
   ) u_max_store (
      .clock     (clock),
      .reset     (reset),
      .cfg_count (max_cnt_ff),
      .ctl       (max_req),
      .value_in  (min_pass),
      .sts       (max_rsp),
      .pass_out  (max_pass)
   );

   assign div_start = (state_ff == S_CALC) && (count_ff != '0);

   tma_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (sum_ff),
      .divisor   (count_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Round up when the remainder reaches count >> 1 (half the count, rounded down)
   assign round_up = (count_ff >= tma_pkg::DATA_W'(2)) && (div_rem >= (count_ff >> 1));

   // Sequencer
   always_comb begin
      state_in         = state_ff;
      sum_in           = sum_ff;
      count_in         = count_ff;
      avg_in           = avg_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_average_in   = rsp_average_ff;
      rsp_ready_res_in = rsp_ready_res_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_kind == tma_pkg::KIND_CLEAR) begin
                  sum_in   = '0;
                  count_in = '0;
                  state_in = S_CALC;
               end else begin
                  state_in = S_MIN;
               end
            end
         end
         S_MIN: begin
            if (min_rsp.done) begin
               state_in = min_rsp.absorbed ? S_CALC : S_MAX;
            end
         end
         S_MAX: begin
            if (max_rsp.done) begin
               if (!max_rsp.absorbed) begin
                  sum_in   = sum_ff + max_pass;
                  count_in = count_ff + tma_pkg::DATA_W'(1);
               end
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            if (count_ff == '0) begin
               avg_in   = '0;
               state_in = S_OUT;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               avg_in   = div_quo + tma_pkg::DATA_W'(round_up);
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // load the output register once the previous response is gone
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in     = 1'b1;
               rsp_average_in   = avg_ff;
               rsp_ready_res_in = (count_ff != '0);
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         min_cnt_ff   <= '0;
         max_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            case (csr_index)
               tma_pkg::CSR_MIN_COUNT: min_cnt_ff <= csr_wdata;
               tma_pkg::CSR_MAX_COUNT: max_cnt_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      avg_ff           <= avg_in;
      rsp_average_ff   <= rsp_average_in;
      rsp_ready_res_ff <= rsp_ready_res_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_average   = rsp_average_ff;
   assign rsp_ready_res = rsp_ready_res_ff;

   // Assertions
   `TMA_ASSERT(a_clear_zeroes, min_req.clear |=> (count_ff == '0 && sum_ff == '0))
   `TMA_ASSERT(a_div_nonzero, div_start |-> (count_ff != '0))
   `TMA_ASSERT_NEVER(a_store_overlap, min_rsp.done && max_rsp.done)
   `TMA_ASSERT(a_busy_after_accept, accept |=> !req_ready)
   `TMA_ASSERT(a_out_holds, (state_ff == S_OUT && rsp_valid && !rsp_ready) |=> state_ff == S_OUT)

endmodule

@@ test/trimmed_mean_checker.sv @@
// ----------------------------------------------------------------------------
// Trimmed mean averager checker
// Watches the request, response and register ports. It predicts the rounded
// mean for each request, including the minima and maxima it keeps aside, and
// compares every response against the oldest prediction.
// ----------------------------------------------------------------------------
module trimmed_mean_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic                       req_kind,
   input  logic [tma_pkg::DATA_W-1:0] req_sample,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [tma_pkg::DATA_W-1:0] rsp_average,
   input  logic                       rsp_ready_res,
   input  logic                       csr_write_en,
   input  logic                       csr_index,
   input  logic [tma_pkg::CNT_W-1:0]  csr_wdata,
   output int unsigned                outstanding,
   output int unsigned                failures
);

   localparam int KEEP_DEPTH = 8;

   typedef struct packed {
      logic [tma_pkg::DATA_W-1:0] average;
      logic                       ready_res;
   } mean_type;

   // Excluded extremes, indexed by the register index of their count
   logic [tma_pkg::DATA_W-1:0] kept [2][KEEP_DEPTH];
   int unsigned                kept_fill [2];
   logic [tma_pkg::CNT_W-1:0]  trim_count [2];
   logic [tma_pkg::DATA_W-1:0] total;
   logic [tma_pkg::DATA_W-1:0] tally;
   mean_type                   expected_means [$];

   // One store: returns 1 when the value is absorbed, else fwd carries the
   // value that goes on (either v itself or the extreme it displaced)
   function automatic bit trim_through(input logic side,
                                       input logic [tma_pkg::DATA_W-1:0] v,
                                       output logic [tma_pkg::DATA_W-1:0] fwd);
      int unsigned n;
      int unsigned pick;
      bit          swap;
      n = (trim_count[side] > KEEP_DEPTH) ? KEEP_DEPTH : trim_count[side];
      fwd = v;
      if (n == 0)
         return 1'b0;
      if (kept_fill[side] < n) begin
         kept[side][kept_fill[side]] = v;
         kept_fill[side]++;
         return 1'b1;
      end
      // strict compare keeps the lowest index on ties
      pick = 0;
      for (int i = 1; i < n; i++) begin
         if (side == tma_pkg::CSR_MIN_COUNT ? kept[side][i] > kept[side][pick]
                                            : kept[side][i] < kept[side][pick])
            pick = i;
      end
      swap = (side == tma_pkg::CSR_MIN_COUNT) ? (v < kept[side][pick])
                                              : (v > kept[side][pick]);
      if (swap) begin
         fwd = kept[side][pick];
         kept[side][pick] = v;
      end
      return 1'b0;
   endfunction

   // Update the running state for one request and return its rounded mean
   function automatic mean_type predict_mean(input logic kind,
                                             input logic [tma_pkg::DATA_W-1:0] sample);
      logic [tma_pkg::DATA_W-1:0] past_min;
      logic [tma_pkg::DATA_W-1:0] past_max;
      mean_type                   r;
      if (kind == tma_pkg::KIND_CLEAR) begin
         kept_fill[tma_pkg::CSR_MIN_COUNT] = 0;
         kept_fill[tma_pkg::CSR_MAX_COUNT] = 0;
         total = '0;
         tally = '0;
      end else if (!trim_through(tma_pkg::CSR_MIN_COUNT, sample, past_min)) begin
         if (!trim_through(tma_pkg::CSR_MAX_COUNT, past_min, past_max)) begin
            total = total + past_max;
            tally = tally + 1;
         end
      end
      r.average = '0;
      r.ready_res = (tally != 0);
      if (tally != 0) begin
         r.average = total / tally;
         if (tally >= 2 && (total % tally) >= (tally / 2))
            r.average = r.average + 1;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      mean_type want;
      if (reset) begin
         kept_fill[tma_pkg::CSR_MIN_COUNT] = 0;
         kept_fill[tma_pkg::CSR_MAX_COUNT] = 0;
         trim_count[tma_pkg::CSR_MIN_COUNT] = '0;
         trim_count[tma_pkg::CSR_MAX_COUNT] = '0;
         total = '0;
         tally = '0;
         expected_means.delete();
         failures = 0;
         outstanding <= 0;
      end else begin
         if (csr_write_en)
            trim_count[csr_index] = csr_wdata;

         // compare before pushing: a response never belongs to a same-edge request
         if (rsp_valid && rsp_ready) begin
            if (expected_means.size() == 0) begin
               $error("unexpected response: average %0h ready_res %0b",
                      rsp_average, rsp_ready_res);
               failures++;
            end else begin
               want = expected_means.pop_front();
               if (rsp_average !== want.average) begin
                  $error("average: expected %0h, got %0h", want.average, rsp_average);
                  failures++;
               end
               if (rsp_ready_res !== want.ready_res) begin
                  $error("ready_res: expected %0b, got %0b", want.ready_res, rsp_ready_res);
                  failures++;
               end
            end
         end

         if (req_valid && req_ready)
            expected_means.push_back(predict_mean(req_kind, req_sample));

         outstanding <= expected_means.size();
      end
   end

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// Trimmed mean averager testbench
// Drives directed and random requests through several count settings and
// idle patterns; a separate checker predicts and compares each response.
// ----------------------------------------------------------------------------
module testbench;

   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int NUM_PHASES      = 10;
   localparam int ITEMS_PER_PHASE = 105;
   localparam int NUM_DIRECTED    = 22;

   // Count settings per phase; a clear in between only at random, so counts may change mid-run
   localparam int MIN_SET [NUM_PHASES] = '{0, 8, 15, 1, 3, 0, 8, 9, 4, 2};
   localparam int MAX_SET [NUM_PHASES] = '{0, 8, 15, 1, 0, 5, 2, 15, 4, 7};

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_kind = tma_pkg::KIND_ADD;
   logic [tma_pkg::DATA_W-1:0] req_sample = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [tma_pkg::DATA_W-1:0] rsp_average;
   logic                       rsp_ready_res;
   logic                       csr_write_en = 1'b0;
   logic                       csr_index = tma_pkg::CSR_MIN_COUNT;
   logic [tma_pkg::CNT_W-1:0]  csr_wdata = '0;
   int unsigned                outstanding;
   int unsigned                failures;
   int unsigned                quiet_cycles = 0;
   int                         gap_pct = 0;
   int                         stall_pct = 0;

   // {kind, sample}: extremes, ties, wraparound of the sum, clears
   logic [tma_pkg::DATA_W:0] directed [NUM_DIRECTED] = '{
      {tma_pkg::KIND_CLEAR, 32'hFFFF_FFFF}, {tma_pkg::KIND_ADD, 32'h0000_0000},
      {tma_pkg::KIND_ADD, 32'hFFFF_FFFF},   {tma_pkg::KIND_ADD, 32'h0000_0007},
      {tma_pkg::KIND_ADD, 32'h0000_0007},   {tma_pkg::KIND_ADD, 32'h0000_0007},
      {tma_pkg::KIND_ADD, 32'h0000_0001},   {tma_pkg::KIND_ADD, 32'h0000_0003},
      {tma_pkg::KIND_ADD, 32'h0000_0003},   {tma_pkg::KIND_ADD, 32'h8000_0000},
      {tma_pkg::KIND_ADD, 32'h7FFF_FFFF},   {tma_pkg::KIND_ADD, 32'hFFFF_FFFF},
      {tma_pkg::KIND_ADD, 32'hFFFF_FFFF},   {tma_pkg::KIND_ADD, 32'hFFFF_FFFE},
      {tma_pkg::KIND_ADD, 32'h0000_0001},   {tma_pkg::KIND_ADD, 32'h0000_0002},
      {tma_pkg::KIND_CLEAR, 32'h5555_AAAA}, {tma_pkg::KIND_ADD, 32'h0000_0005},
      {tma_pkg::KIND_ADD, 32'hAAAA_5555},   {tma_pkg::KIND_ADD, 32'h0000_0000},
      {tma_pkg::KIND_ADD, 32'h0000_0000},   {tma_pkg::KIND_ADD, 32'h0000_0003}
   };

   trimmed_mean_averager DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_sample    (req_sample),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_average   (rsp_average),
      .rsp_ready_res (rsp_ready_res),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   trimmed_mean_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_sample    (req_sample),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_average   (rsp_average),
      .rsp_ready_res (rsp_ready_res),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .outstanding   (outstanding),
      .failures      (failures)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Watchdog: ends the run after too long without any transfer
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Mix of full-range, tiny (for ties), extreme and near-max samples
   function automatic logic [tma_pkg::DATA_W-1:0] random_sample();
      case ($urandom_range(3))
         0: return $urandom();
         1: return $urandom_range(15);
         2: return $urandom_range(1) ? '1 : '0;
         default: return 32'hFFFF_FFF0 | $urandom_range(15);
      endcase
   endfunction

   task automatic send_request(input logic kind, input logic [tma_pkg::DATA_W-1:0] sample);
      int gap;
      gap = 0;
      while ($urandom_range(99) < gap_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_sample <= sample;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   // Stop sending and wait until every response has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (outstanding != 0);
   endtask

   task automatic write_csr(input logic index, input int value);
      csr_write_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value[tma_pkg::CNT_W-1:0];
      @(posedge clock);
   endtask

   task automatic program_counts(input int min_value, input int max_value);
      write_csr(tma_pkg::CSR_MIN_COUNT, min_value);
      write_csr(tma_pkg::CSR_MAX_COUNT, max_value);
      csr_write_en <= 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed requests with two extremes kept on each side
      program_counts(2, 2);
      for (int i = 0; i < NUM_DIRECTED; i++)
         send_request(directed[i][tma_pkg::DATA_W], directed[i][tma_pkg::DATA_W-1:0]);

      // Random phases, cycling the idle pattern
      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_drained();
         case (p % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 70; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 70; end
            default: begin gap_pct = 36; stall_pct = 36; end
         endcase
         program_counts(MIN_SET[p], MAX_SET[p]);
         if ($urandom_range(2) == 0)
            send_request(tma_pkg::KIND_CLEAR, $urandom());
         repeat (ITEMS_PER_PHASE) begin
            if ($urandom_range(99) < 3)
               send_request(tma_pkg::KIND_CLEAR, $urandom());
            else
               send_request(tma_pkg::KIND_ADD, random_sample());
         end
      end

      wait_drained();
      repeat (100) @(posedge clock);
      if (failures == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
